@@ hw/rtl/csg_bool_stack_eval_check_macros.svh @@
// Assertion macros for the checker file of this block, csgc_sva.sv.
`ifndef CSG_BOOL_STACK_EVAL_CHECK_MACROS_SVH
`define CSG_BOOL_STACK_EVAL_CHECK_MACROS_SVH

// Property sampled on the rising clock edge and ignored while reset is low.
`define CSGC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// A stalled channel keeps its valid high and its payload stable.
`define CSGC_ASSERT_STALL(lbl, clk, rst_n, vld, rdy, pay, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (vld && !rdy) |=> (vld && $stable(pay))) \
        else $error(msg);

`endif

@@ hw/rtl/csgc_pkg.sv @@
`default_nettype none

package csgc_pkg;

    localparam int STACK_DEPTH  = 16;
    localparam int MAX_ELEMENTS = 1024;

    // Stack fill count runs from 0 to STACK_DEPTH.
    localparam int SP_W  = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W = $clog2(MAX_ELEMENTS);
    // Signed checker depth, saturating at plus and minus MAX_ELEMENTS.
    localparam int DEP_W = $clog2(MAX_ELEMENTS) + 2;
    localparam int POS_W = 10;

    localparam logic [1:0] MODE_BODY = 2'd0;
    localparam logic [1:0] MODE_COMB = 2'd1;

    localparam logic [2:0] OP_SET  = 3'd0;
    localparam logic [2:0] OP_PUSH = 3'd1;
    localparam logic [2:0] OP_OR   = 3'd2;
    localparam logic [2:0] OP_ADD  = 3'd3;
    localparam logic [2:0] OP_AND  = 3'd4;
    localparam logic [2:0] OP_MUL  = 3'd5;
    localparam logic [2:0] OP_XOR  = 3'd6;
    localparam logic [2:0] OP_SUB  = 3'd7;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd1;
    localparam logic [2:0] ERR_NEED_SET  = 3'd2;
    localparam logic [2:0] ERR_BAD_OP    = 3'd3;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd4;
    localparam logic [2:0] ERR_UNCLOSED  = 3'd5;

    typedef struct packed {
        logic [1:0] mode;
        logic [2:0] op;
        logic       body_inside;
        logic       last;
    } t_elem;

    typedef struct packed {
        logic [2:0]       code;
        logic [POS_W-1:0] pos;
    } t_verdict;

    function automatic logic is_set_push(input logic [2:0] op);
        return (op == OP_SET) || (op == OP_PUSH);
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/csg_bool_stack_eval_check.sv @@
// Channel  Direction  Handshake                  Payload
// in       request    i_in_valid / o_in_ready    i_mode, i_combine_op, i_body_inside, i_last
// out      result     o_out_valid / i_out_ready  o_inside_res, o_error_code, o_error_position
// cfg      write      i_cfg_we                   i_cfg_data (stop on error)
//
// One request is taken per cycle while no result is stalled; a request marked last
// shows its result in the cycle after. The single result register sets the rate: a new
// request waits only while a result is held and not being taken in the same cycle.
// Reset is synchronous and active low; it clears the stack, the checker and the result.
// A stalled result holds off every request, whether it carries the last mark or not.
`default_nettype none

module csg_bool_stack_eval_check (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_in_valid,
    output logic       o_in_ready,
    input  wire  [1:0] i_mode,
    input  wire  [2:0] i_combine_op,
    input  wire        i_body_inside,
    input  wire        i_last,
    output logic       o_out_valid,
    input  wire        i_out_ready,
    output logic       o_inside_res,
    output logic [2:0] o_error_code,
    output logic [csgc_pkg::POS_W-1:0] o_error_position,
    input  wire        i_cfg_we,
    input  wire        i_cfg_data
);
    import csgc_pkg::*;

    t_elem            elem;
    t_verdict         verdict;
    logic             bottom_next;
    logic             step;
    logic             r_stop_on_error;
    logic             r_out_valid;
    logic             r_inside;
    logic [2:0]       r_code;
    logic [POS_W-1:0] r_pos;

    assign elem.mode        = i_mode;
    assign elem.op          = i_combine_op;
    assign elem.body_inside = i_body_inside;
    assign elem.last        = i_last;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign step       = i_in_valid && o_in_ready;

    csgc_eval u_eval (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_step        (step),
        .i_elem        (elem),
        .o_bottom_next (bottom_next)
    );

    csgc_rules u_rules (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_step          (step),
        .i_elem          (elem),
        .i_stop_on_error (r_stop_on_error),
        .o_verdict       (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_on_error <= 1'b0;
        end else if (i_cfg_we) begin
            r_stop_on_error <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step && i_last) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Any error forces the inside bit low.
    always_ff @(posedge i_clk) begin
        if (step && i_last) begin
            r_inside <= (verdict.code == ERR_NONE) ? bottom_next : 1'b0;
            r_code   <= verdict.code;
            r_pos    <= verdict.pos;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_inside_res     = r_inside;
    assign o_error_code     = r_code;
    assign o_error_position = r_pos;

endmodule

`default_nettype wire

@@ hw/rtl/csgc_eval.sv @@
`default_nettype none

module csgc_eval (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_step,
    input  csgc_pkg::t_elem i_elem,
    output logic            o_bottom_next
);
    import csgc_pkg::*;

    localparam logic [SP_W-1:0] CNT_ONE  = SP_W'(1);
    localparam logic [SP_W-1:0] CNT_TWO  = SP_W'(2);
    localparam logic [SP_W-1:0] CNT_FULL = SP_W'(STACK_DEPTH);

    // Stack held top-first: entry 0 is the top, so every read is at a fixed tap.
    logic [STACK_DEPTH-1:0] r_stk;
    logic [STACK_DEPTH-1:0] n_stk;
    logic [SP_W-1:0]        r_cnt;
    logic [SP_W-1:0]        n_cnt;
    // Copy of the bottom entry, which the result reports.
    logic                   r_bot;
    logic                   n_bot;
    logic                   mrg_a;
    logic                   mrg_b;
    logic                   mrg;

    function automatic logic merge_bit(input logic [2:0] op, input logic a,
                                       input logic b);
        case (op)
            OP_OR, OP_ADD:  return a | b;
            OP_AND, OP_MUL: return a & b;
            OP_XOR:         return a ^ b;
            OP_SUB:         return a & ~b;
            default:        return a;
        endcase
    endfunction

    always_comb begin
        if (i_elem.mode == MODE_BODY) begin
            mrg_a = r_stk[0];
            mrg_b = i_elem.body_inside;
        end else begin
            mrg_a = r_stk[1];
            mrg_b = r_stk[0];
        end
        mrg = merge_bit(i_elem.op, mrg_a, mrg_b);
    end

    always_comb begin
        n_stk = r_stk;
        n_cnt = r_cnt;
        n_bot = r_bot;
        if (i_elem.mode == MODE_BODY) begin
            if (r_cnt == '0 || is_set_push(i_elem.op)) begin
                // A push onto a full stack is dropped.
                if (r_cnt != CNT_FULL) begin
                    n_stk = {r_stk[STACK_DEPTH-2:0], i_elem.body_inside};
                    n_cnt = r_cnt + CNT_ONE;
                    if (r_cnt == '0) begin
                        n_bot = i_elem.body_inside;
                    end
                end
            end else begin
                n_stk[0] = mrg;
                if (r_cnt == CNT_ONE) begin
                    n_bot = mrg;
                end
            end
        end else if (i_elem.mode == MODE_COMB) begin
            if (r_cnt >= CNT_TWO) begin
                n_stk    = {1'b0, r_stk[STACK_DEPTH-1:1]};
                n_stk[0] = mrg;
                n_cnt    = r_cnt - CNT_ONE;
                if (r_cnt == CNT_TWO) begin
                    n_bot = mrg;
                end
            end else if (r_cnt == CNT_ONE) begin
                // Popping the only entry empties the stack; the bottom keeps its bit.
                n_cnt = '0;
            end
        end
    end

    assign o_bottom_next = n_bot;

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_stk <= n_stk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_bot <= 1'b0;
        end else if (i_step) begin
            if (i_elem.last) begin
                r_cnt <= '0;
                r_bot <= 1'b0;
            end else begin
                r_cnt <= n_cnt;
                r_bot <= n_bot;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/csgc_rules.sv @@
`default_nettype none

module csgc_rules (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_step,
    input  csgc_pkg::t_elem    i_elem,
    input  wire                i_stop_on_error,
    output csgc_pkg::t_verdict o_verdict
);
    import csgc_pkg::*;

    localparam logic signed [DEP_W-1:0] D_MAX  = DEP_W'(MAX_ELEMENTS);
    localparam logic signed [DEP_W-1:0] D_MIN  = DEP_W'(-MAX_ELEMENTS);
    localparam logic signed [DEP_W-1:0] D_SD   = DEP_W'(STACK_DEPTH);
    localparam logic signed [DEP_W-1:0] D_ZERO = DEP_W'(0);
    localparam logic signed [DEP_W-1:0] D_ONE  = DEP_W'(1);
    localparam logic signed [DEP_W-1:0] D_NEG1 = DEP_W'(-1);
    localparam logic [IDX_W-1:0]        IDX_END = IDX_W'(MAX_ELEMENTS - 1);
    localparam logic [IDX_W-1:0]        IDX_ONE = IDX_W'(1);

    logic signed [DEP_W-1:0] r_depth;
    logic signed [DEP_W-1:0] n_depth;
    logic                    r_first;
    logic                    n_first;
    logic                    r_stop;
    logic                    n_stop;
    logic [2:0]              r_err;
    logic [2:0]              n_err;
    logic [POS_W-1:0]        r_epos;
    logic [POS_W-1:0]        n_epos;
    logic [IDX_W-1:0]        r_idx;
    logic [IDX_W-1:0]        n_idx;
    logic [IDX_W+POS_W-1:0]  idx_ext;
    logic [POS_W-1:0]        pos;
    logic                    sp;

    assign idx_ext = {{POS_W{1'b0}}, r_idx};
    assign pos     = idx_ext[POS_W-1:0];
    assign sp      = is_set_push(i_elem.op);
    assign n_idx   = (r_idx == IDX_END) ? '0 : r_idx + IDX_ONE;

    always_comb begin
        n_depth = r_depth;
        n_first = r_first;
        n_stop  = r_stop;
        n_err   = r_err;
        n_epos  = r_epos;
        if (i_elem.mode == MODE_BODY && !r_stop) begin
            if (sp) begin
                if (r_depth < D_MAX) begin
                    n_depth = r_depth + D_ONE;
                end
                if (n_depth >= D_SD) begin
                    n_err  = ERR_OVERFLOW;
                    n_epos = pos;
                    n_stop = i_stop_on_error;
                end
            end else if (!r_first) begin
                n_depth = D_ZERO;
                n_err   = ERR_NEED_SET;
                n_epos  = pos;
                n_stop  = i_stop_on_error;
            end
            n_first = 1'b1;
        end else if (i_elem.mode == MODE_COMB && !r_stop) begin
            if (sp) begin
                n_err  = ERR_BAD_OP;
                n_epos = pos;
                n_stop = i_stop_on_error;
            end
            // With stop-on-error, a bad operator ends checking before the pop.
            if (!n_stop) begin
                if (r_depth > D_MIN) begin
                    n_depth = r_depth - D_ONE;
                end
                if (n_depth < D_ZERO) begin
                    n_err  = ERR_UNDERFLOW;
                    n_epos = pos;
                    n_stop = i_stop_on_error;
                end
            end
        end
    end

    always_comb begin
        o_verdict.code = n_err;
        o_verdict.pos  = n_epos;
        if (n_err == ERR_NONE && n_depth > D_ZERO) begin
            o_verdict.code = ERR_UNCLOSED;
            o_verdict.pos  = pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= D_NEG1;
            r_first <= 1'b0;
            r_stop  <= 1'b0;
            r_err   <= ERR_NONE;
            r_epos  <= '0;
            r_idx   <= '0;
        end else if (i_step) begin
            if (i_elem.last) begin
                r_depth <= D_NEG1;
                r_first <= 1'b0;
                r_stop  <= 1'b0;
                r_err   <= ERR_NONE;
                r_epos  <= '0;
                r_idx   <= '0;
            end else begin
                r_depth <= n_depth;
                r_first <= n_first;
                r_stop  <= n_stop;
                r_err   <= n_err;
                r_epos  <= n_epos;
                r_idx   <= n_idx;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/csgc_sva.sv @@
`default_nettype none

`include "csg_bool_stack_eval_check_macros.svh"

module csgc_sva (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_in_valid,
    input wire        o_in_ready,
    input wire        i_last,
    input wire        o_out_valid,
    input wire        i_out_ready,
    input wire        o_inside_res,
    input wire  [2:0] o_error_code,
    input wire  [csgc_pkg::POS_W-1:0] o_error_position
);
    import csgc_pkg::*;

    logic             in_acc;
    logic             out_stall;
    logic             last_acc;
    logic             out_err;
    logic             out_ok;
    logic [POS_W+3:0] out_pay;

    assign in_acc    = i_in_valid && o_in_ready;
    assign out_stall = o_out_valid && !i_out_ready;
    assign last_acc  = in_acc && i_last;
    assign out_err   = o_out_valid && (o_error_code != ERR_NONE);
    assign out_ok    = o_out_valid && (o_error_code == ERR_NONE);
    assign out_pay   = {o_inside_res, o_error_code, o_error_position};

    `CSGC_ASSERT_STALL(a_out_hold, i_clk, i_rst_n, o_out_valid, i_out_ready, out_pay,
                       "result changed while stalled")

    // A result shows only when it was held over or a last request was taken.
    `CSGC_ASSERT(a_out_src, i_clk, i_rst_n,
                 o_out_valid |-> ($past(out_stall) || $past(last_acc)),
                 "result without a last request")

    `CSGC_ASSERT(a_err_inside, i_clk, i_rst_n, out_err |-> !o_inside_res,
                 "inside bit set on an error result")

    `CSGC_ASSERT(a_ok_pos, i_clk, i_rst_n, out_ok |-> (o_error_position == '0),
                 "position set on a clean result")

endmodule

bind csg_bool_stack_eval_check csgc_sva u_sva (.*);

`default_nettype wire
